// File: design/lbcc_pkg.sv
// shared types, constants and helpers for the bank conflict cycle counter
package lbcc_pkg;

    localparam int MAX_LANES_DEF    = 64;
    localparam int ADDRESS_BITS_DEF = 18;
    localparam int QUEUE_DEPTH      = 4;
    localparam int BANK_BITS        = 6;
    localparam int BANK_SLICES      = 4;
    localparam int SLICE_DEPTH      = 16;
    localparam int COUNT_W          = 5;
    localparam int FILL_W           = 5;
    localparam int SUM_W            = 8;
    localparam int OUT_FIELDS_W     = 2 * SUM_W + 2;
    localparam int OUT_TDATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_DWORD_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IS_WRITE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_BANK_MODE = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_MISALIGNED = 2'd1,
        ERR_PARTIAL    = 2'd2,
        ERR_OVERFLOW   = 2'd3
    } error_code_t;

    typedef struct packed {
        logic [BANK_BITS-1:0] dword_low;
        logic                 misaligned;
        logic                 last;
    } lane_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] dword_count;
        logic                  is_write;
        logic                  wide_bank_mode;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic error_code_t max_error(error_code_t a, error_code_t b);
        return (b > a) ? b : a;
    endfunction

endpackage

// File: design/lbcc_front.sv
// front end: accepts lane addresses and classifies them into queue entries
module lbcc_front #(
    parameter int ADDRESS_BITS = lbcc_pkg::ADDRESS_BITS_DEF
) (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ADDRESS_BITS-1:0] lane_address,
    input  logic                    last_lane,
    input  lbcc_pkg::queue_status_t q_status,
    output logic                    push,
    output lbcc_pkg::lane_item_t    item
);

    assign s_tready        = !q_status.full;
    assign push            = s_tvalid && !q_status.full;
    assign item.dword_low  = lane_address[lbcc_pkg::BANK_BITS+1:2];
    assign item.misaligned = |lane_address[1:0];
    assign item.last       = last_lane;

endmodule

// File: design/lbcc_queue.sv
// short queue between the front end and the bank counting back end
module lbcc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lbcc_pkg::lane_item_t    push_item,
    input  logic                    pop,
    output lbcc_pkg::lane_item_t    head_item,
    output lbcc_pkg::queue_status_t status
);

    localparam int DEPTH = lbcc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbcc_pkg::lane_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// File: design/lbcc_back.sv
// back end: per-bank hit counting, group peaks, cycle sums and result register
module lbcc_back #(
    parameter int MAX_LANES = lbcc_pkg::MAX_LANES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lbcc_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  lbcc_pkg::lane_item_t         item,
    output logic                         pop,
    input  logic                         m_tready,
    output logic                         out_valid,
    output logic [lbcc_pkg::SUM_W-1:0]   total_cycles,
    output logic [lbcc_pkg::SUM_W-1:0]   data_cycles,
    output lbcc_pkg::error_code_t        error_code
);

    localparam int LANE_W  = $clog2(MAX_LANES + 1);
    localparam int SLICES  = lbcc_pkg::BANK_SLICES;
    localparam int SDEPTH  = lbcc_pkg::SLICE_DEPTH;
    localparam int IDX_W   = $clog2(SDEPTH);
    localparam int CNT_W   = lbcc_pkg::COUNT_W;
    localparam int FILL_W  = lbcc_pkg::FILL_W;
    localparam int SUM_W   = lbcc_pkg::SUM_W;
    localparam int BANK_W  = lbcc_pkg::BANK_BITS;

    logic [CNT_W-1:0] count_reg [SLICES][SDEPTH];

    logic [LANE_W-1:0]     lanes_reg, lanes_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]      peak_reg, peak_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    lbcc_pkg::error_code_t err_reg, err_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]      total_reg;
    logic [SUM_W-1:0]      data_reg;
    lbcc_pkg::error_code_t code_reg;

    logic [2:0]        dwords;
    logic              wide_read;
    logic              bank64;
    logic [FILL_W-1:0] group_size;
    logic              counted;
    logic              close_now;
    logic              close_last;
    logic              close_any;
    logic [CNT_W-1:0]  peak_new;
    logic [FILL_W-1:0] fill_new;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_new;
    logic [SUM_W-1:0]  issue;
    lbcc_pkg::error_code_t err_new;

    logic [1:0]        slice_k   [SLICES];
    logic              slice_hit [SLICES];
    logic [BANK_W-1:0] slice_bank[SLICES];
    logic [IDX_W-1:0]  slice_idx [SLICES];
    logic [CNT_W-1:0]  slice_inc [SLICES];

    always_comb
    begin
        case (cfg.dword_count) inside
            3'd0:         dwords = 3'd1;
            [3'd1:3'd4]:  dwords = cfg.dword_count;
            default:      dwords = 3'd4;
        endcase

        wide_read = cfg.wide_bank_mode && !cfg.is_write;
        bank64    = wide_read && (dwords == 3'd2 || dwords == 3'd4);

        if (wide_read)
        begin
            case (dwords)
                3'd3:    group_size = FILL_W'(4);
                3'd4:    group_size = FILL_W'(8);
                default: group_size = FILL_W'(16);
            endcase
        end
        else
        begin
            case (dwords)
                3'd1:    group_size = FILL_W'(16);
                3'd2:    group_size = FILL_W'(8);
                default: group_size = FILL_W'(4);
            endcase
        end

        counted = (lanes_reg < LANE_W'(MAX_LANES));

        // consecutive dwords of one lane land in distinct slices
        for (int s = 0; s < SLICES; s++)
        begin
            slice_k[s]    = 2'(s) - item.dword_low[1:0];
            slice_hit[s]  = counted && ({1'b0, slice_k[s]} < dwords);
            slice_bank[s] = item.dword_low + BANK_W'(slice_k[s]);
            if (!bank64)
            begin
                slice_bank[s][BANK_W-1] = 1'b0;
            end
            slice_idx[s]  = slice_bank[s][BANK_W-1:2];
            slice_inc[s]  = count_reg[s][slice_idx[s]];
            if (slice_inc[s] != '1)
            begin
                slice_inc[s] = slice_inc[s] + 1'b1;
            end
        end

        peak_new = peak_reg;
        for (int s = 0; s < SLICES; s++)
        begin
            if (slice_hit[s] && slice_inc[s] > peak_new)
            begin
                peak_new = slice_inc[s];
            end
        end

        fill_new   = counted ? fill_reg + 1'b1 : fill_reg;
        close_now  = counted && (fill_new >= group_size);
        close_last = item.last && !close_now && (fill_new != '0);
        close_any  = close_now || close_last;

        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(peak_new);
        if (!close_any)
        begin
            sum_new = sum_reg;
        end
        else if (sum_wide[SUM_W])
        begin
            sum_new = '1;
        end
        else
        begin
            sum_new = sum_wide[SUM_W-1:0];
        end

        err_new = err_reg;
        if (!counted)
        begin
            err_new = lbcc_pkg::max_error(err_new, lbcc_pkg::ERR_OVERFLOW);
        end
        if (counted && item.misaligned)
        begin
            err_new = lbcc_pkg::max_error(err_new, lbcc_pkg::ERR_MISALIGNED);
        end
        if (close_last)
        begin
            err_new = lbcc_pkg::max_error(err_new, lbcc_pkg::ERR_PARTIAL);
        end

        issue = SUM_W'(4);
        if (cfg.is_write)
        begin
            issue = SUM_W'(4) + SUM_W'({dwords, 2'b00});
        end
    end

    assign pop = q_valid && (!item.last || !out_valid_reg || m_tready);

    always_comb
    begin
        lanes_next     = lanes_reg;
        fill_next      = fill_reg;
        peak_next      = peak_reg;
        sum_next       = sum_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop)
        begin
            if (item.last)
            begin
                lanes_next     = '0;
                fill_next      = '0;
                peak_next      = '0;
                sum_next       = '0;
                err_next       = lbcc_pkg::ERR_NONE;
                out_valid_next = 1'b1;
            end
            else
            begin
                lanes_next = counted ? lanes_reg + 1'b1 : lanes_reg;
                fill_next  = close_any ? '0 : fill_new;
                peak_next  = close_any ? '0 : peak_new;
                sum_next   = sum_new;
                err_next   = err_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg     <= '0;
            fill_reg      <= '0;
            peak_reg      <= '0;
            sum_reg       <= '0;
            err_reg       <= lbcc_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lanes_reg     <= lanes_next;
            fill_reg      <= fill_next;
            peak_reg      <= peak_next;
            sum_reg       <= sum_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLICES; s++)
            begin
                for (int i = 0; i < SDEPTH; i++)
                begin
                    count_reg[s][i] <= '0;
                end
            end
        end
        else if (pop)
        begin
            if (item.last || close_any)
            begin
                for (int s = 0; s < SLICES; s++)
                begin
                    for (int i = 0; i < SDEPTH; i++)
                    begin
                        count_reg[s][i] <= '0;
                    end
                end
            end
            else
            begin
                for (int s = 0; s < SLICES; s++)
                begin
                    if (slice_hit[s])
                    begin
                        count_reg[s][slice_idx[s]] <= slice_inc[s];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && item.last)
        begin
            total_reg <= (issue > sum_new) ? issue : sum_new;
            data_reg  <= sum_new;
            code_reg  <= err_new;
        end
    end

    assign out_valid    = out_valid_reg;
    assign total_cycles = total_reg;
    assign data_cycles  = data_reg;
    assign error_code   = code_reg;

endmodule

// File: design/lds_bank_conflict_cycle_counter_top.sv
// top level of the shared-memory bank conflict cycle counter
//
// Takes one lane byte address per cycle on the slave stream while the queue
// has room (tlast marks the final lane of an instruction) and returns one
// result per instruction on the master stream. A four-entry queue separates
// the address front end from the bank counting back end, which retires one
// lane per cycle unless a final lane waits for the previous result to be
// taken: each lane updates up to four bank counters and the group peak
// together. The result is registered at the edge where the final lane
// leaves the queue and sits in an output register, so lanes of the next
// instruction keep flowing while it waits. Bank counters are flip-flops
// cleared by reset, so no clearing pass is needed. Configuration registers
// take effect on the lanes processed after the write.
module lds_bank_conflict_cycle_counter_top #(
    parameter int MAX_LANES    = lbcc_pkg::MAX_LANES_DEF,
    parameter int ADDRESS_BITS = lbcc_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // lane_address
    input  logic [((ADDRESS_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // total_cycles, data_cycles, error_code
    output logic [lbcc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lbcc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lbcc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    lbcc_pkg::cfg_t          cfg_reg;
    lbcc_pkg::queue_status_t q_status;
    lbcc_pkg::lane_item_t    push_item;
    lbcc_pkg::lane_item_t    head_item;
    logic                    push;
    logic                    pop;
    logic [lbcc_pkg::SUM_W-1:0] total_cycles;
    logic [lbcc_pkg::SUM_W-1:0] data_cycles;
    lbcc_pkg::error_code_t   error_code;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dword_count    <= 3'd1;
            cfg_reg.is_write       <= 1'b0;
            cfg_reg.wide_bank_mode <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lbcc_pkg::CFG_DWORD_COUNT:    cfg_reg.dword_count    <= cfg_data;
                lbcc_pkg::CFG_IS_WRITE:       cfg_reg.is_write       <= cfg_data[0];
                lbcc_pkg::CFG_WIDE_BANK_MODE: cfg_reg.wide_bank_mode <= cfg_data[0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    lbcc_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .lane_address (s_tdata[ADDRESS_BITS-1:0]),
        .last_lane    (s_tlast),
        .q_status     (q_status),
        .push         (push),
        .item         (push_item)
    );

    lbcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    lbcc_back #(
        .MAX_LANES (MAX_LANES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (!q_status.empty),
        .item         (head_item),
        .pop          (pop),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .total_cycles (total_cycles),
        .data_cycles  (data_cycles),
        .error_code   (error_code)
    );

    assign m_tdata = lbcc_pkg::OUT_TDATA_W'({error_code, data_cycles, total_cycles});

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.last) |=> m_tvalid)
        else $error("final lane retired without a result");

    a_total_covers_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (total_cycles >= data_cycles && total_cycles >= 8'd4))
        else $error("total cycles below data or issue cycles");
`endif

endmodule
